FILE: hw/rtl/tcnw_pkg.sv
// Shared types, constants and helpers of the text console number writer.
package tcnw_pkg;

    localparam int VALUE_W      = 64;
    localparam int DIGITS_W     = 80;
    localparam int COUNT_W      = 5;
    localparam int ITER_W       = 7;
    localparam int ROW_W        = 5;
    localparam int COL_W        = 7;
    localparam int BASE_W       = 12;
    localparam int INDEX_W      = 11;
    localparam int DEC_DIGITS   = 20;

    localparam logic [COUNT_W-1:0] HEX_COUNT    = 5'd16;
    localparam logic [COUNT_W-1:0] DEC_COUNT    = 5'd20;
    localparam logic [ITER_W-1:0]  DABBLE_STEPS = 7'd64;

    localparam logic [1:0] ACT_CHAR = 2'd0;
    localparam logic [1:0] ACT_HEX  = 2'd1;
    localparam logic [1:0] ACT_DEC  = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_X       = 8'h78;
    localparam logic [7:0] CHAR_A       = 8'h41;

    typedef struct packed {
        logic advance;
        logic newline;
    } cursor_cmd_t;

    typedef struct packed {
        logic load_hex;
        logic load_dec;
        logic shift;
    } digit_cmd_t;

    typedef struct packed {
        logic               busy;
        logic [3:0]         digit;
        logic [COUNT_W-1:0] count;
    } digit_status_t;

    // Map a digit 0..15 to its upper-case ASCII code.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] code;
        if (d < 4'd10)
        begin
            code = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            code = CHAR_A + {4'd0, d} - 8'd10;
        end
        return code;
    endfunction

endpackage

FILE: hw/rtl/tcnw_in_if.sv
// Input item channel of the text console number writer.
interface tcnw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  character;
    logic [63:0] value;
    logic [7:0]  attribute;

    modport source (output valid, action, character, value, attribute, input ready);
    modport sink   (input valid, action, character, value, attribute, output ready);
endinterface

FILE: hw/rtl/tcnw_out_if.sv
// Cell write channel of the text console number writer.
interface tcnw_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] cell_index;
    logic [15:0] cell_word;
    logic        last;

    modport source (output valid, cell_index, cell_word, last, input ready);
    modport sink   (input valid, cell_index, cell_word, last, output ready);
endinterface

FILE: hw/rtl/text_console_number_writer_top.sv
// Top level of the text console number writer: sequencer and output register.
//
// Accepts one item at a time and turns it into cell writes for a text screen of
// COLUMNS by ROWS cells, at most one write per cycle while the sink keeps ready high.
// A character item is accepted and then written; a newline only moves the
// cursor and is done in the accept cycle. A hex item is accepted, writes the
// "0x" prefix, then shifts the digit register once for each of its 16 nibbles,
// whether the nibble is a suppressed leading zero or an emitted digit, with one
// more step where the skip hands over to the first emitted digit. A decimal
// item is accepted, runs 64 steps of the shift-add-3 unit in the digit block,
// waits to see it finish, then shifts through its 20 digits, skipping leading
// zeros and emitting digits, again with the hand-over step. A finished write
// that waits in the output register for the sink stalls the sequencer while
// it has a write to make.
// The cursor keeps a running row base so the cell index needs no multiplier.
module text_console_number_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    tcnw_in_if.sink     req,
    tcnw_out_if.source  cell_wr
);
    import tcnw_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHAR   = 7'b0000010,
        S_PRE0   = 7'b0000100,
        S_PREX   = 7'b0001000,
        S_DABBLE = 7'b0010000,
        S_SKIP   = 7'b0100000,
        S_DIGIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] char_reg, char_next;
    logic [7:0] attr_reg, attr_next;

    // Output register: holds one finished cell write until the sink takes it.
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [15:0]        out_word_reg, out_word_next;
    logic               out_last_reg, out_last_next;

    cursor_cmd_t        cursor_cmd;
    digit_cmd_t         digit_cmd;
    digit_status_t      digit_status;
    logic [INDEX_W-1:0] cursor_index;
    logic               accept;
    logic               emit_ok;
    logic               emit;
    logic [7:0]         emit_char;
    logic               emit_last;

    tcnw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cursor_cmd),
        .cell_index (cursor_index)
    );

    tcnw_digits u_digits (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (digit_cmd),
        .value  (req.value),
        .status (digit_status)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    // The output register can take a new write when empty or being drained.
    assign emit_ok   = !out_valid_reg || cell_wr.ready;

    always_comb
    begin
        state_next = state_reg;
        char_next  = char_reg;
        attr_next  = attr_reg;
        cursor_cmd = '0;
        digit_cmd  = '0;
        emit       = 1'b0;
        emit_char  = char_reg;
        emit_last  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    attr_next = req.attribute;
                    char_next = req.character;
                    if (req.action == ACT_CHAR)
                    begin
                        if (req.character == CHAR_NEWLINE)
                        begin
                            cursor_cmd.newline = 1'b1;
                        end
                        else
                        begin
                            state_next = S_CHAR;
                        end
                    end
                    else if (req.action == ACT_HEX)
                    begin
                        digit_cmd.load_hex = 1'b1;
                        state_next         = S_PRE0;
                    end
                    else if (req.action == ACT_DEC)
                    begin
                        digit_cmd.load_dec = 1'b1;
                        state_next         = S_DABBLE;
                    end
                end
            end
            S_CHAR:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PRE0:
            begin
                emit_char = CHAR_ZERO;
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    state_next = S_PREX;
                end
            end
            S_PREX:
            begin
                emit_char = CHAR_X;
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    state_next = S_SKIP;
                end
            end
            S_DABBLE:
            begin
                // Wait for the shift-add-3 pass to finish.
                if (!digit_status.busy)
                begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Drop leading zeros, keeping at least one digit.
                if (digit_status.digit == 4'd0 && digit_status.count > 5'd1)
                begin
                    digit_cmd.shift = 1'b1;
                end
                else
                begin
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                emit_char = digit_char(digit_status.digit);
                emit_last = (digit_status.count == 5'd1);
                if (emit_ok)
                begin
                    emit            = 1'b1;
                    digit_cmd.shift = 1'b1;
                    if (digit_status.count == 5'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // Every cell write advances the cursor past the written cell.
        if (emit)
        begin
            cursor_cmd.advance = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_index_next = cursor_index;
            out_word_next  = {attr_reg, emit_char};
            out_last_next  = emit_last;
        end
        else if (cell_wr.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        attr_reg      <= attr_next;
        out_index_reg <= out_index_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
    end

    assign cell_wr.valid      = out_valid_reg;
    assign cell_wr.cell_index = out_index_reg;
    assign cell_wr.cell_word  = out_word_reg;
    assign cell_wr.last       = out_last_reg;

endmodule

FILE: hw/rtl/tcnw_cursor.sv
// Row and column cursor with a running row base for the cell index.
module tcnw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcnw_pkg::cursor_cmd_t          cmd,
    output logic [tcnw_pkg::INDEX_W-1:0]   cell_index
);
    import tcnw_pkg::*;

    localparam logic [COL_W:0]    COL_LIMIT = (COL_W+1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROW_LIMIT = (ROW_W+1)'(ROWS);
    localparam logic [BASE_W-1:0] ROW_STEP  = BASE_W'(COLUMNS);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              wrap_row;
    logic [BASE_W:0]   index_sum;

    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign index_sum = {1'b0, base_reg} + {{(BASE_W-COL_W+1){1'b0}}, col_reg};
    assign cell_index = index_sum[INDEX_W-1:0];

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        wrap_row  = 1'b0;
        if (cmd.newline)
        begin
            col_next = '0;
            wrap_row = 1'b1;
        end
        else if (cmd.advance)
        begin
            if (col_inc >= COL_LIMIT)
            begin
                col_next = '0;
                wrap_row = 1'b1;
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
        if (wrap_row)
        begin
            if (row_inc >= ROW_LIMIT)
            begin
                row_next  = '0;
                base_next = '0;
            end
            else
            begin
                row_next  = row_inc[ROW_W-1:0];
                base_next = base_reg + ROW_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

FILE: hw/rtl/tcnw_digits.sv
// Digit register with a shared shift-add-3 unit for binary to decimal.
module tcnw_digits (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcnw_pkg::digit_cmd_t            cmd,
    input  logic [tcnw_pkg::VALUE_W-1:0]    value,
    output tcnw_pkg::digit_status_t         status
);
    import tcnw_pkg::*;

    logic [DIGITS_W-1:0] digits_reg, digits_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [DIGITS_W-1:0] adjusted;

    // Add 3 to every decimal digit of 5 or more before the next doubling.
    always_comb
    begin
        logic [3:0] nib;
        adjusted = '0;
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            nib = digits_reg[i*4 +: 4];
            adjusted[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    always_comb
    begin
        digits_next = digits_reg;
        bin_next    = bin_reg;
        count_next  = count_reg;
        iter_next   = iter_reg;
        priority if (cmd.load_hex)
        begin
            digits_next = {value, {(DIGITS_W-VALUE_W){1'b0}}};
            count_next  = HEX_COUNT;
            iter_next   = '0;
        end
        else if (cmd.load_dec)
        begin
            digits_next = '0;
            bin_next    = value;
            count_next  = DEC_COUNT;
            iter_next   = DABBLE_STEPS;
        end
        else if (iter_reg != '0)
        begin
            digits_next = {adjusted[DIGITS_W-2:0], bin_reg[VALUE_W-1]};
            bin_next    = {bin_reg[VALUE_W-2:0], 1'b0};
            iter_next   = iter_reg - 1'b1;
        end
        else if (cmd.shift)
        begin
            digits_next = {digits_reg[DIGITS_W-5:0], 4'd0};
            count_next  = count_reg - 1'b1;
        end
        else
        begin
            // Hold every register.
            count_next  = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        bin_reg    <= bin_next;
    end

    assign status.busy  = (iter_reg != '0);
    assign status.digit = digits_reg[DIGITS_W-1 -: 4];
    assign status.count = count_reg;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the text console number writer: directed table, random items, stalls.
`timescale 1ns / 1ps

module tb_top;
    import tcnw_pkg::*;

    // Screen geometry handed to the block and mirrored by the cursor model.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    // Code that the block must ignore: no cell write, no cursor move.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Longest hold-off of the sink, in cycles, while the source keeps offering.
    localparam int HOLD_OFF_CYCLES = 400;
    // Cycles in which neither side moves an item before the run is called hung.
    localparam int WATCHDOG_LIMIT  = 4000;
    // Quiet cycles after the last cell write.
    localparam int DRAIN_CYCLES    = 150;
    localparam int RANDOM_PER_PHASE = 140;

    localparam string HEX_GLYPHS = "0123456789ABCDEF";

    typedef struct packed {
        logic [10:0] index;
        logic [15:0] word;
        logic        last;
    } cell_write_t;

    typedef cell_write_t cell_list_t[$];

    // One stimulus row; a non-empty text means the cells are typed in here,
    // written from base onward, instead of taken from the cursor model.
    typedef struct {
        logic [1:0]  action;
        logic [7:0]  code;
        logic [63:0] value;
        logic [7:0]  attr;
        string       text;
        int          base;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tcnw_in_if  req_ch ();
    tcnw_out_if wr_ch ();

    text_console_number_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch.sink),
        .cell_wr (wr_ch.source)
    );

    // Cursor of the model and the cell writes still owed by the block.
    int          pen_row;
    int          pen_col;
    cell_write_t owed_cells[$];
    int          mismatches;

    // What the source is offering right now, as seen by the monitor.
    string       offer_text;
    int          offer_base;

    // Idle percentages per side and the sink hold-off counter.
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_off_left;

    int          quiet_cycles;

    // Directed rows. The cursor is known after reset, so most first rows carry
    // their cells typed in: extremes of every field, zero in both bases and
    // the widest hex and decimal values. The rest go through the model:
    // newline, the ignored action, every hex digit, and enough wide decimal
    // items to wrap the column.
    stim_row_t directed_rows[] = '{
        '{ACT_CHAR,   8'h41, 64'd0,                  8'h07, "A",                    0},
        '{ACT_CHAR,   8'hFF, 64'd0,                  8'hFF, "\377",                 1},
        '{ACT_CHAR,   8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, "",                    0},
        '{ACT_HEX,    8'h00, 64'd0,                  8'h1F, "0x0",                  3},
        '{ACT_HEX,    8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h2E, "0xFFFFFFFFFFFFFFFF",  6},
        '{ACT_DEC,    8'h00, 64'd0,                  8'h80, "0",                   24},
        '{ACT_DEC,    8'h55, 64'hFFFF_FFFF_FFFF_FFFF, 8'h01, "18446744073709551615", 25},
        '{ACT_CHAR,   CHAR_NEWLINE, 64'd0,           8'h07, "",                    0},
        '{ACT_UNUSED, CHAR_NEWLINE, 64'hDEAD_BEEF_0123_4567, 8'hAA, "",            0},
        '{ACT_HEX,    8'h00, 64'h0123_4567_89AB_CDEF, 8'h3C, "",                    0},
        '{ACT_DEC,    8'h00, 64'd10,                 8'h4B, "",                    0},
        '{ACT_HEX,    8'h00, 64'h8000_0000_0000_0000, 8'h5A, "",                    0},
        '{ACT_DEC,    8'h00, 64'd10000000000000000000, 8'hA5, "",                  0},
        '{ACT_CHAR,   8'h5A, 64'd0,                  8'hA5, "",                    0},
        '{ACT_DEC,    8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 8'h0F, "",                    0},
        '{ACT_DEC,    8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 8'hF0, "",                    0},
        '{ACT_DEC,    8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 8'h33, "",                    0},
        '{ACT_DEC,    8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 8'hCC, "",                    0},
        '{ACT_CHAR,   8'h7E, 64'd0,                  8'h00, "",                    0},
        '{ACT_CHAR,   CHAR_NEWLINE, 64'd0,           8'hFF, "",                    0},
        '{ACT_UNUSED, 8'h00, 64'd0,                  8'h00, "",                    0}
    };

    // Clock: 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Step the cursor to column 0 of the next row, wrapping after the last row.
    function automatic void next_line();
        pen_col = 0;
        pen_row = pen_row + 1;
        if (pen_row >= ROWS)
        begin
            pen_row = 0;
        end
    endfunction

    // Cell writes caused by one item; advance the model cursor as a side effect.
    function automatic void render_cells(input logic [1:0] action, input logic [7:0] code,
                                         input logic [63:0] value, input logic [7:0] attr,
                                         output cell_list_t cells);
        logic [7:0]  glyphs[$];
        logic [7:0]  digits[20];
        logic [63:0] rest;
        int          nd;
        cell_write_t cw;

        cells = {};
        rest  = value;
        nd    = 0;
        case (action)
            ACT_CHAR:
            begin
                if (code == CHAR_NEWLINE)
                begin
                    next_line();
                    return;
                end
                glyphs.push_back(code);
            end
            ACT_HEX:
            begin
                glyphs.push_back(CHAR_ZERO);
                glyphs.push_back(CHAR_X);
                do
                begin
                    digits[nd] = HEX_GLYPHS[int'(rest[3:0])];
                    nd++;
                    rest = rest >> 4;
                end
                while (rest != 64'd0 && nd < 16);
            end
            ACT_DEC:
            begin
                do
                begin
                    digits[nd] = CHAR_ZERO + 8'(rest % 64'd10);
                    nd++;
                    rest = rest / 64'd10;
                end
                while (rest != 64'd0 && nd < 20);
            end
            default:
            begin
                return;
            end
        endcase
        // Digits were collected least significant first.
        for (int i = nd - 1; i >= 0; i--)
        begin
            glyphs.push_back(digits[i]);
        end
        foreach (glyphs[i])
        begin
            cw.index = 11'(pen_row * COLUMNS + pen_col);
            cw.word  = {attr, glyphs[i]};
            cw.last  = (i == glyphs.size() - 1);
            cells.push_back(cw);
            pen_col++;
            if (pen_col >= COLUMNS)
            begin
                next_line();
            end
        end
    endfunction

    // Check every accepted cell write first, then queue what a newly accepted
    // item owes; a write can never belong to an item accepted at the same edge.
    always @(posedge clk)
    begin
        cell_list_t  fresh;
        cell_write_t want;

        if (rst_n)
        begin
            if (wr_ch.valid && wr_ch.ready)
            begin
                if (owed_cells.size() == 0)
                begin
                    $error("unexpected cell write: cell_index %0d cell_word %h last %b",
                           wr_ch.cell_index, wr_ch.cell_word, wr_ch.last);
                    mismatches++;
                end
                else
                begin
                    want = owed_cells.pop_front();
                    if (wr_ch.cell_index !== want.index)
                    begin
                        $error("cell_index: expected %0d, got %0d", want.index,
                               wr_ch.cell_index);
                        mismatches++;
                    end
                    if (wr_ch.cell_word !== want.word)
                    begin
                        $error("cell_word: expected %h, got %h", want.word, wr_ch.cell_word);
                        mismatches++;
                    end
                    if (wr_ch.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, wr_ch.last);
                        mismatches++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                // Run the model for every item so its cursor stays in step.
                render_cells(req_ch.action, req_ch.character, req_ch.value,
                             req_ch.attribute, fresh);
                if (offer_text.len() > 0)
                begin
                    // Replace the model's cells with the typed-in ones.
                    fresh = {};
                    for (int i = 0; i < offer_text.len(); i++)
                    begin
                        want.index = 11'(offer_base + i);
                        want.word  = {req_ch.attribute, offer_text[i]};
                        want.last  = (i == offer_text.len() - 1);
                        fresh.push_back(want);
                    end
                end
                foreach (fresh[i])
                begin
                    owed_cells.push_back(fresh[i]);
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (wr_ch.valid && wr_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** text_console_number_writer_top: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sink side: drop ready at random, or hold it low for the whole hold-off.
    initial
    begin
        wr_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                wr_ch.ready = 1'b0;
                hold_off_left--;
            end
            else
            begin
                wr_ch.ready = ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Offer one item from a falling edge; return at the falling edge after it
    // was taken. Valid stays high straight into the next item unless we idle.
    task automatic offer_item(input stim_row_t row);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.action    = row.action;
        req_ch.character = row.code;
        req_ch.value     = row.value;
        req_ch.attribute = row.attr;
        offer_text       = row.text;
        offer_base       = row.base;
        req_ch.valid     = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Random item: mostly characters and numbers, some newlines, a few ignored.
    function automatic stim_row_t random_item();
        stim_row_t row;
        int        pick;

        pick       = $urandom_range(99);
        row.text   = "";
        row.base   = 0;
        row.attr   = 8'($urandom_range(255));
        row.code   = 8'($urandom_range(255));
        case ($urandom_range(9))
            0:       row.value = 64'd0;
            1:       row.value = '1;
            default: row.value = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        if (pick < 40)
        begin
            row.action = ACT_CHAR;
            if ($urandom_range(4) == 0)
            begin
                row.code = CHAR_NEWLINE;
            end
        end
        else if (pick < 65)
        begin
            row.action = ACT_HEX;
        end
        else if (pick < 90)
        begin
            row.action = ACT_DEC;
        end
        else
        begin
            row.action = ACT_UNUSED;
        end
        return row;
    endfunction

    // Random phase: set both idle rates, then offer a batch of items.
    task automatic run_phase(input int src_pct, input int snk_pct, input int count);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (count)
        begin
            offer_item(random_item());
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_CHAR;
        req_ch.character = 8'h00;
        req_ch.value     = 64'd0;
        req_ch.attribute = 8'h00;
        offer_text       = "";
        offer_base       = 0;
        pen_row          = 0;
        pen_col          = 0;
        mismatches       = 0;
        quiet_cycles     = 0;
        hold_off_left    = 0;
        src_idle_pct     = 37;
        snk_idle_pct     = 70;

        // Hold reset, then release it on a falling edge.
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table under the first idle mix.
        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i]);
        end

        run_phase(37, 70, RANDOM_PER_PHASE);
        run_phase(70, 37, RANDOM_PER_PHASE);

        // Hold off the sink for a long stretch while the source keeps offering,
        // so the block backs up and stalls its input; then run with no idling.
        hold_off_left = HOLD_OFF_CYCLES;
        run_phase(0, 0, RANDOM_PER_PHASE);
        req_ch.valid = 1'b0;

        // Wait for every owed cell write, then watch for stray ones.
        while (owed_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("** text_console_number_writer_top: PASSED **");
        end
        else
        begin
            $display("** text_console_number_writer_top: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/tcnw_pkg.sv
hw/rtl/tcnw_in_if.sv
hw/rtl/tcnw_out_if.sv
hw/rtl/tcnw_cursor.sv
hw/rtl/tcnw_digits.sv
hw/rtl/text_console_number_writer_top.sv
bench/tb_top.sv
